@@ hw/rtl/ppv_pkg.sv @@
// ----------------------------------------------------------------------------
// ppv_pkg
// Shared types and constants for the point projection core.
// ----------------------------------------------------------------------------
package ppv_pkg;

  localparam int WORD_W   = 32;
  localparam int ACC_W    = 64;
  localparam int MARGIN_W = 31;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 64;
  localparam int MAT_REGS = 6;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [ACC_W-1:0]         mag_t;

  // Register index of the image size word; matrix words sit below it
  localparam logic [CFG_AW-1:0] REG_IMAGE_SIZE = 3'd6;

  localparam word_t SAT_MAX = 32'sh7FFF_FFFF;
  localparam word_t SAT_MIN = 32'sh8000_0000;

endpackage

@@ hw/rtl/ppv_proj.sv @@
// ----------------------------------------------------------------------------
// ppv_proj
// Matrix times homogeneous point: registered products, then registered sums.
// ----------------------------------------------------------------------------
module ppv_proj import ppv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  en,
  input  word_t mat_i [3][4],
  input  word_t pt_i  [3],
  output acc_t  row_o [3]
);

  acc_t  prod_r [3][3];
  word_t off_r  [3];
  acc_t  row_r  [3];

  // Stage 1: nine exact products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= acc_t'(mat_i[r][c]) * acc_t'(pt_i[c]);
        end
        off_r[r] <= mat_i[r][3];
      end
    end
  end

  // Stage 2: floor-shifted products plus offset column
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        row_r[r] <= acc_t'(off_r[r]) + (prod_r[r][0] >>> FRAC_BITS)
                    + (prod_r[r][1] >>> FRAC_BITS) + (prod_r[r][2] >>> FRAC_BITS);
      end
    end
  end

  assign row_o = row_r;

endmodule

@@ hw/rtl/ppv_div.sv @@
// ----------------------------------------------------------------------------
// ppv_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module ppv_div #(
  parameter int NW = 80,
  parameter int DW = 64,
  parameter int QB = 34,
  parameter int TW = 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic [QB-1:0] quo_o,
  output logic          big_o,
  output logic [TW-1:0] tag_o
);

  logic [DW-1:0] rem_r [QB+1];
  logic [QB-1:0] low_r [QB+1];
  logic [QB-1:0] quo_r [QB+1];
  logic [DW-1:0] den_r [QB+1];
  logic          big_r [QB+1];
  logic [TW-1:0] tag_r [QB+1];

  logic [NW-1:0] hi;
  logic          big0;

  // Entry: quotient too wide for QB bits when the high part reaches the divisor
  assign hi   = num_i >> QB;
  assign big0 = hi >= NW'(den_i);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi[DW-1:0];
      low_r[0] <= num_i[QB-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den_i;
      big_r[0] <= big0;
      tag_r[0] <= tag_i;
    end
  end

  // One shift-compare-subtract per stage
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        take;

    assign trial = {rem_r[k], low_r[k][QB-1]};
    assign diff  = trial - {1'b0, den_r[k]};
    assign take  = trial >= {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
        low_r[k+1] <= {low_r[k][QB-2:0], 1'b0};
        quo_r[k+1] <= {quo_r[k][QB-2:0], take};
        den_r[k+1] <= den_r[k];
        big_r[k+1] <= big_r[k];
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  assign quo_o = quo_r[QB];
  assign big_o = big_r[QB];
  assign tag_o = tag_r[QB];

endmodule

@@ hw/rtl/project_point_with_view_test_core.sv @@
// ----------------------------------------------------------------------------
// project_point_with_view_test_core
// 3x4 pinhole projection with perspective divide, saturation and view test.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  in      | in_valid/in_stall, point, margin   | beat in
//  out     | out_valid/out_stall, u, v, flags   | beat out
//  cfg     | cfg_we, cfg_addr, cfg_wdata        | register write
//
//  One beat per cycle sustained while out_stall does not hold the output beat; the
//  pipeline depth is set by the bit-per-stage dividers.
//  Synchronous active-low reset clears the valid bits and the configuration registers.
//  A stalled output freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
module project_point_with_view_test_core import ppv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_point_x,
  input  logic signed [31:0]  in_point_y,
  input  logic signed [31:0]  in_point_z,
  input  logic [MARGIN_W-1:0] in_pixel_margin,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_pixel_u,
  output logic signed [31:0]  out_pixel_v,
  output logic                out_in_view,
  output logic                out_zero_depth,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata
);

  localparam int QB  = (FRAC_BITS + 18 > 33) ? FRAC_BITS + 18 : 33;
  localparam int NW  = ACC_W + FRAC_BITS;
  localparam int LAT = QB + 3;
  localparam int UTW = MARGIN_W + 3;

  logic [CFG_DW-1:0]   mat_reg_r [MAT_REGS];
  logic [31:0]         img_r;
  word_t               mat [3][4];
  word_t               pt [3];
  acc_t                row [3];
  logic                en;
  logic [LAT-1:0]      vld_r;
  logic [MARGIN_W-1:0] mgn_s1_r, mgn_s2_r;
  logic [NW-1:0]       num_u, num_v;
  mag_t                den;
  logic [UTW-1:0]      tag_u, tag_u_o;
  logic [1:0]          tag_v, tag_v_o;
  logic [QB-1:0]       quo_u, quo_v;
  logic                big_u, big_v;
  logic                out_valid_r;
  word_t               u_r, v_r, u_nxt, v_nxt;
  logic                view_r, view_nxt, zero_r;
  logic [MARGIN_W-1:0] mgn;
  acc_t                lo_b, hi_u, hi_v;

  function automatic mag_t mag_of(acc_t a);
    return a[ACC_W-1] ? mag_t'(-a) : mag_t'(a);
  endfunction

  function automatic word_t sat_coord(logic [QB-1:0] q, logic big, logic neg);
    logic over;
    if (neg) begin
      over = big || (q > QB'(64'h8000_0000));
      return over ? SAT_MIN : word_t'(32'd0 - q[31:0]);
    end
    over = big || (q[QB-1:31] != '0);
    return over ? SAT_MAX : word_t'(q[31:0]);
  endfunction

  function automatic logic in_range(logic [QB-1:0] q, logic big, logic neg,
                                    acc_t lo, acc_t hi);
    acc_t val;
    val = neg ? -acc_t'(q) : acc_t'(q);
    return !big && (val >= lo) && (val <= hi);
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_REGS; i++) begin
        mat_reg_r[i] <= '0;
      end
      img_r <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_IMAGE_SIZE) begin
        img_r <= cfg_wdata[31:0];
      end
      for (int i = 0; i < MAT_REGS; i++) begin
        if (cfg_addr == CFG_AW'(i)) begin
          mat_reg_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // Unpack matrix words: even column low, odd column high
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mat[r][0] = word_t'(mat_reg_r[2*r][31:0]);
      mat[r][1] = word_t'(mat_reg_r[2*r][63:32]);
      mat[r][2] = word_t'(mat_reg_r[2*r+1][31:0]);
      mat[r][3] = word_t'(mat_reg_r[2*r+1][63:32]);
    end
  end

  // Global advance: a held output beat freezes every stage
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign pt[0]     = in_point_x;
  assign pt[1]     = in_point_y;
  assign pt[2]     = in_point_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], in_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // Margin rides alongside the projection stages
  always_ff @(posedge clk) begin
    if (en) begin
      mgn_s1_r <= in_pixel_margin;
      mgn_s2_r <= mgn_s1_r;
    end
  end

  ppv_proj #(.FRAC_BITS(FRAC_BITS)) u_proj (
    .clk   (clk),
    .en    (en),
    .mat_i (mat),
    .pt_i  (pt),
    .row_o (row)
  );

  // Divider operands: magnitudes with signs and special flags as tags
  assign num_u = {mag_of(row[0]), {FRAC_BITS{1'b0}}};
  assign num_v = {mag_of(row[1]), {FRAC_BITS{1'b0}}};
  assign den   = mag_of(row[2]);
  assign tag_u = {(row[2] == '0), (row[0] != '0), row[0][ACC_W-1] ^ row[2][ACC_W-1],
                  mgn_s2_r};
  assign tag_v = {(row[1] != '0), row[1][ACC_W-1] ^ row[2][ACC_W-1]};

  ppv_div #(.NW(NW), .DW(ACC_W), .QB(QB), .TW(UTW)) u_div_u (
    .clk   (clk),
    .en    (en),
    .num_i (num_u),
    .den_i (den),
    .tag_i (tag_u),
    .quo_o (quo_u),
    .big_o (big_u),
    .tag_o (tag_u_o)
  );

  ppv_div #(.NW(NW), .DW(ACC_W), .QB(QB), .TW(2)) u_div_v (
    .clk   (clk),
    .en    (en),
    .num_i (num_v),
    .den_i (den),
    .tag_i (tag_v),
    .quo_o (quo_v),
    .big_o (big_v),
    .tag_o (tag_v_o)
  );

  // Final stage: sign, saturation and bounds
  assign mgn  = tag_u_o[MARGIN_W-1:0];
  assign lo_b = -acc_t'(mgn);
  assign hi_u = (acc_t'(img_r[15:0]) <<< FRAC_BITS) + acc_t'(mgn);
  assign hi_v = (acc_t'(img_r[31:16]) <<< FRAC_BITS) + acc_t'(mgn);

  always_comb begin
    if (tag_u_o[UTW-1]) begin
      u_nxt    = tag_u_o[UTW-2] ? (tag_u_o[UTW-3] ? SAT_MIN : SAT_MAX) : '0;
      v_nxt    = tag_v_o[1] ? (tag_v_o[0] ? SAT_MIN : SAT_MAX) : '0;
      view_nxt = 1'b0;
    end else begin
      u_nxt    = sat_coord(quo_u, big_u, tag_u_o[UTW-3]);
      v_nxt    = sat_coord(quo_v, big_v, tag_v_o[0]);
      view_nxt = in_range(quo_u, big_u, tag_u_o[UTW-3], lo_b, hi_u) &&
                 in_range(quo_v, big_v, tag_v_o[0], lo_b, hi_v);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r    <= u_nxt;
      v_r    <= v_nxt;
      view_r <= view_nxt;
      zero_r <= tag_u_o[UTW-1];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_u    = u_r;
  assign out_pixel_v    = v_r;
  assign out_in_view    = view_r;
  assign out_zero_depth = zero_r;

  // A zero denominator never reports a point in view
  a_zero_not_view: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_depth) |-> !out_in_view)
    else $error("zero_depth beat flagged in view");

  // A beat leaving the last divider stage reaches the output register
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LAT-1] && !in_stall) |=> out_valid)
    else $error("beat lost between divider and output");

endmodule
